### src/rbd_pkg.sv
package rbd_pkg;

    localparam int PIX_W      = 8;
    localparam int POS_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE         = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_SIZE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd3;

    localparam logic [2:0] DS_POS0  = 3'd0;
    localparam logic [2:0] DS_POS1  = 3'd1;
    localparam logic [2:0] DS_WIDTH = 3'd2;
    localparam logic [2:0] DS_CH0   = 3'd3;
    localparam logic [2:0] DS_CH1   = 3'd4;
    localparam logic [2:0] DS_CH2   = 3'd5;

    typedef struct packed {
        logic       load;
        logic       go;
        logic [2:0] div_src;
        logic       cap_q0;
        logic       cap_rem1;
        logic       acc;
        logic       cap_m0;
        logic       cap_m1;
        logic       push;
    } t_cmd;

    typedef struct packed {
        logic emit;
        logic out_free;
    } t_status;

endpackage

### src/rbd_controller.sv
module rbd_controller (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  rbd_pkg::t_status i_status,
    output rbd_pkg::t_cmd   o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_POS0 = 4'd1;
    localparam logic [3:0] S_POS1 = 4'd2;
    localparam logic [3:0] S_POS2 = 4'd3;
    localparam logic [3:0] S_ACC  = 4'd4;
    localparam logic [3:0] S_DIV0 = 4'd5;
    localparam logic [3:0] S_DIV1 = 4'd6;
    localparam logic [3:0] S_DIV2 = 4'd7;
    localparam logic [3:0] S_PUSH = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.div_src = rbd_pkg::DS_POS0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_POS0;
                end
            end
            S_POS0: begin
                o_cmd.go      = 1'b1;
                o_cmd.div_src = rbd_pkg::DS_POS0;
                n_state       = S_POS1;
            end
            S_POS1: begin
                o_cmd.cap_q0  = 1'b1;
                o_cmd.go      = 1'b1;
                o_cmd.div_src = rbd_pkg::DS_POS1;
                n_state       = S_POS2;
            end
            S_POS2: begin
                o_cmd.cap_rem1 = 1'b1;
                o_cmd.go       = 1'b1;
                o_cmd.div_src  = rbd_pkg::DS_WIDTH;
                n_state        = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = i_status.emit ? S_DIV0 : S_IDLE;
            end
            S_DIV0: begin
                o_cmd.go      = 1'b1;
                o_cmd.div_src = rbd_pkg::DS_CH0;
                n_state       = S_DIV1;
            end
            S_DIV1: begin
                o_cmd.cap_m0  = 1'b1;
                o_cmd.go      = 1'b1;
                o_cmd.div_src = rbd_pkg::DS_CH1;
                n_state       = S_DIV2;
            end
            S_DIV2: begin
                o_cmd.cap_m1  = 1'b1;
                o_cmd.go      = 1'b1;
                o_cmd.div_src = rbd_pkg::DS_CH2;
                n_state       = S_PUSH;
            end
            S_PUSH: begin
                if (i_status.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### src/rbd_datapath.sv
module rbd_datapath #(
    parameter int MAX_WIDTH = 2048,
    parameter int MAX_GROUP = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rbd_pkg::t_cmd                     i_cmd,
    output rbd_pkg::t_status                  o_status,
    input  logic                              i_cfg_valid,
    input  logic [rbd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rbd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [rbd_pkg::IN_DATA_W-1:0]     i_s_tdata,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [rbd_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    output logic                              o_m_tlast
);

    localparam int PW  = rbd_pkg::PIX_W;
    localparam int PSW = rbd_pkg::POS_W;
    localparam int SW  = PW + $clog2(MAX_GROUP);
    localparam int DW  = $clog2(MAX_GROUP + 1);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int XB0 = (SW > WW) ? SW : WW;
    localparam int XB  = (XB0 > 12) ? XB0 : 12;
    localparam int K   = XB + DW;
    localparam int RW  = K + 1;

    // config
    logic        r_mode;
    logic [4:0]  r_group_size;
    logic [11:0] r_image_width;
    logic [11:0] r_image_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= 1'b0;
            r_group_size   <= 5'd2;
            r_image_width  <= 12'd2048;
            r_image_height <= 12'd2048;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rbd_pkg::CFG_MODE:         r_mode         <= i_cfg_data[0];
                rbd_pkg::CFG_GROUP_SIZE:   r_group_size   <= i_cfg_data[4:0];
                rbd_pkg::CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                rbd_pkg::CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [DW-1:0] w_g;
    logic [XB-1:0] w_w;
    logic [11:0]   w_h;

    always_comb begin
        if (r_group_size < 5'd2) begin
            w_g = DW'(2);
        end else if (int'(r_group_size) > MAX_GROUP) begin
            w_g = DW'(MAX_GROUP);
        end else begin
            w_g = DW'(r_group_size);
        end
        if (r_image_width == 12'd0) begin
            w_w = XB'(1);
        end else if (int'(r_image_width) > MAX_WIDTH) begin
            w_w = XB'(MAX_WIDTH);
        end else begin
            w_w = XB'(r_image_width);
        end
        if (r_image_height == 12'd0) begin
            w_h = 12'd1;
        end else if (r_image_height > 12'd2048) begin
            w_h = 12'd2048;
        end else begin
            w_h = r_image_height;
        end
    end

    // position state
    logic [PSW-1:0] r_col;
    logic [PSW-1:0] r_row;
    logic [DW-1:0]  r_fill;
    logic [11:0]    w_col_p1;
    logic [11:0]    w_row_p1;
    logic           w_last_col;
    logic           w_last_row;

    assign w_col_p1   = {1'b0, r_col} + 12'd1;
    assign w_row_p1   = {1'b0, r_row} + 12'd1;
    assign w_last_col = XB'(w_col_p1) >= w_w;
    assign w_last_row = w_row_p1 >= w_h;

    // reciprocal table
    logic [RW-1:0] w_recip [0:MAX_GROUP];

    for (genvar gi = 0; gi <= MAX_GROUP; gi++) begin : g_recip
        localparam longint RV = (gi == 0) ? 0 : (((longint'(1) << K) + gi - 1) / gi);
        assign w_recip[gi] = RW'(RV);
    end

    // shared divide unit
    logic [PW-1:0]     r_px [0:2];
    logic [SW-1:0]     r_sum [0:2];
    logic [DW-1:0]     r_n;
    logic [XB-1:0]     w_dx;
    logic [DW-1:0]     w_dd;
    logic [XB+RW-1:0]  w_prod;
    logic [XB-1:0]     r_dx;
    logic [DW-1:0]     r_dd;
    logic [XB-1:0]     r_q;
    logic [XB+DW-1:0]  w_qd;
    logic [XB-1:0]     w_rem;
    logic [DW-1:0]     w_rem_s;

    always_comb begin
        w_dd = w_g;
        unique case (i_cmd.div_src)
            rbd_pkg::DS_POS0:  w_dx = r_mode ? XB'(r_row) : XB'(r_col);
            rbd_pkg::DS_POS1:  w_dx = XB'(w_col_p1);
            rbd_pkg::DS_WIDTH: w_dx = w_w;
            rbd_pkg::DS_CH0: begin
                w_dx = XB'(r_sum[0]);
                w_dd = r_n;
            end
            rbd_pkg::DS_CH1: begin
                w_dx = XB'(r_sum[1]);
                w_dd = r_n;
            end
            default: begin
                w_dx = XB'(r_sum[2]);
                w_dd = r_n;
            end
        endcase
    end

    assign w_prod  = {{RW{1'b0}}, w_dx} * {{XB{1'b0}}, w_recip[w_dd]};
    assign w_qd    = {{DW{1'b0}}, r_q} * {{XB{1'b0}}, r_dd};
    assign w_rem   = r_dx - w_qd[XB-1:0];
    assign w_rem_s = w_rem[DW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.go) begin
            r_dx <= w_dx;
            r_dd <= w_dd;
            r_q  <= w_prod[K +: XB];
        end
    end

    // accumulate
    logic [3*SW-1:0] r_colmem [0:MAX_WIDTH-1];
    logic [3*SW-1:0] r_mem_rd;
    logic [SW-1:0]   r_rowsum [0:2];
    logic [SW-1:0]   w_new [0:2];
    logic [AW-1:0]   w_addr;
    logic [PSW-1:0]  r_oidx;
    logic [DW-1:0]   r_phase;
    logic [DW-1:0]   r_rem1;
    logic [DW-1:0]   w_n_row;
    logic [DW-1:0]   w_n_col;
    logic            w_row_close;
    logic            w_col_emit;
    logic [XB-1:0]   w_col_ext;

    assign w_col_ext   = XB'(r_col);
    assign w_addr      = w_col_ext[AW-1:0];
    assign w_n_row     = r_fill + DW'(1);
    assign w_n_col     = r_phase + DW'(1);
    assign w_row_close = w_last_col || (w_n_row >= w_g) || (r_row[0] && (r_rem1 == w_rem_s));
    assign w_col_emit  = (w_n_col >= w_g) || w_last_row;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_mode) begin
                w_new[k] = ((r_phase == '0) ? '0 : r_mem_rd[k*SW +: SW]) + SW'(r_px[k]);
            end else begin
                w_new[k] = ((r_fill == '0) ? '0 : r_rowsum[k]) + SW'(r_px[k]);
            end
        end
    end

    assign o_status.emit     = r_mode ? w_col_emit : w_row_close;
    assign o_status.out_free = !o_m_tvalid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc && r_mode) begin
            r_colmem[w_addr] <= {w_new[2], w_new[1], w_new[0]};
        end
        r_mem_rd <= r_colmem[w_addr];
    end

    logic [PSW-1:0] r_orow;
    logic [PSW-1:0] r_ocol;
    logic           r_flast;
    logic [PW-1:0]  r_mean0;
    logic [PW-1:0]  r_mean1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px[0] <= i_s_tdata[0 +: PW];
            r_px[1] <= i_s_tdata[PW +: PW];
            r_px[2] <= i_s_tdata[2*PW +: PW];
        end
        if (i_cmd.cap_q0) begin
            r_oidx  <= r_q[PSW-1:0];
            r_phase <= w_rem_s;
        end
        if (i_cmd.cap_rem1) begin
            r_rem1 <= w_rem_s;
        end
        if (i_cmd.acc) begin
            for (int k = 0; k < 3; k++) begin
                r_sum[k] <= w_new[k];
                if (!r_mode) begin
                    r_rowsum[k] <= w_new[k];
                end
            end
            r_n     <= r_mode ? w_n_col : w_n_row;
            r_orow  <= r_mode ? r_oidx : r_row;
            r_ocol  <= r_mode ? r_col : r_oidx;
            r_flast <= w_last_row && w_last_col;
        end
        if (i_cmd.cap_m0) begin
            r_mean0 <= r_q[PW-1:0];
        end
        if (i_cmd.cap_m1) begin
            r_mean1 <= r_q[PW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_fill <= '0;
        end else if (i_cmd.acc) begin
            if (w_last_col) begin
                r_col  <= '0;
                r_fill <= '0;
                r_row  <= w_last_row ? '0 : (r_row + PSW'(1));
            end else begin
                r_col <= r_col + PSW'(1);
                if (!r_mode) begin
                    r_fill <= w_row_close ? '0 : w_n_row;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_tvalid <= 1'b0;
        end else if (i_cmd.push) begin
            o_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            o_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            o_m_tdata <= {2'b00, r_ocol, r_orow, r_q[PW-1:0], r_mean1, r_mean0};
            o_m_tlast <= r_flast;
        end
    end

endmodule

### src/rgb_box_decimator_unit.sv
// Box-filter decimator for 8-bit RGB pixels in raster order. Mode 0 averages
// group_size pixels along each row (even rows grouped from the left, odd rows
// from the right), mode 1 averages group_size pixels down each column using a
// per-column sum memory of MAX_WIDTH entries. Means are truncated. Every pixel
// passes through one shared reciprocal multiplier that resolves the group
// position and then, for a pixel that closes a group, the three channel means
// one after another; a result may wait on an output stall. The next pixel is
// taken only once that pixel is done. Configuration may be written whenever no
// pixel is in flight; a change in mid-frame applies from the next pixel on.
module rgb_box_decimator_unit #(
    parameter int MAX_WIDTH = 2048,
    parameter int MAX_GROUP = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [rbd_pkg::IN_DATA_W-1:0]  i_s_tdata,   // red_in, green_in, blue_in
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [rbd_pkg::OUT_DATA_W-1:0] o_m_tdata,   // red_mean, green_mean, blue_mean, out_row, out_col, zero pad
    output logic                           o_m_tlast,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [rbd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rbd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    rbd_pkg::t_cmd    w_cmd;
    rbd_pkg::t_status w_status;

    assign o_cfg_ready = 1'b1;

    rbd_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    rbd_datapath #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_GROUP (MAX_GROUP)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

### src/rbd_checker.sv
module rbd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           o_s_tready,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [rbd_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input logic                           o_m_tlast
);

    // stalled output transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("stalled output changed");

    // one pixel in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input taken while busy");

    // pad bits stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[47:46] == 2'b00)
        else $error("output pad bits set");

    // a new result appears only while the input side is busy
    a_result_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(!o_s_tready))
        else $error("result without pixel");

endmodule

bind rgb_box_decimator_unit rbd_checker u_rbd_checker (.*);
